### rtl/mjt_pkg.sv
// shared types and constants of the minimum-jerk trajectory sampler
`timescale 1ns / 1ps

package mjt_pkg;

    // normalized time s = t / T in Q0.30, 1/T in Q.40, guard fraction bits
    localparam int S_BITS   = 30;
    localparam int INV_BITS = 40;
    localparam int GUARD    = 8;
    localparam int SETUP_K  = 32 - GUARD;
    localparam int MULQ_LAT = 4;
    localparam int DUR_W    = 26;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_START_POS = 3'd0;
    localparam logic [IDX_W-1:0] REG_END_POS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_VEL = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_VEL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_START_ACC = 3'd4;
    localparam logic [IDX_W-1:0] REG_END_ACC   = 3'd5;
    localparam logic [IDX_W-1:0] REG_DURATION  = 3'd6;

    localparam logic [DUR_W-1:0] DUR_RESET = 26'd3000000;
    localparam logic [63:0]      TS_BIAS   = 64'd500000;
    localparam logic [63:0]      IT_NUM    = 64'd1000000 << INV_BITS;
    localparam logic [5:0]       DIV_LAST  = 6'd63;

    // T in Q.32 = dur * 4294 + floor((dur * 15114 + 7812) / 15625),
    // the division done as a multiply by ceil(2^54 / 15625)
    localparam logic [38:0] TS_INT   = 39'd4294;
    localparam logic [39:0] TS_FRAC  = 40'd15114;
    localparam logic [39:0] TS_HALF  = 40'd7812;
    localparam logic [40:0] TS_RECIP = 41'd1152921504607;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

    // setup multiplier operations
    localparam logic [2:0] OP_TS  = 3'd0;
    localparam logic [2:0] OP_TS2 = 3'd1;
    localparam logic [2:0] OP_V0  = 3'd2;
    localparam logic [2:0] OP_VF  = 3'd3;
    localparam logic [2:0] OP_W0  = 3'd4;
    localparam logic [2:0] OP_WF  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV_IT,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_COEF,
        ST_SCALE
    } t_setup_state;

    // travels with each sample down the pipeline
    typedef struct packed {
        logic [S_BITS-1:0] s;
        logic              done;
    } t_side;

    // per-segment coefficients, stable while samples flow
    typedef struct packed {
        logic signed [63:0] n5;
        logic signed [63:0] n4;
        logic signed [63:0] n3;
        logic signed [63:0] w0;
        logic signed [63:0] w0x2;
        logic signed [63:0] v0x2;
        logic signed [63:0] q0x2;
        logic signed [63:0] n5x5;
        logic signed [63:0] n4x4;
        logic signed [63:0] n3x3;
        logic signed [63:0] n5x20;
        logic signed [63:0] n4x12;
        logic signed [63:0] n3x6;
        logic [59:0]        inv_t;
        logic [31:0]        end_pos;
        logic [31:0]        end_vel;
        logic [31:0]        end_acc;
        logic [DUR_W-1:0]   dur;
    } t_coef;

endpackage

### rtl/mjt_mulq.sv
// pipelined signed-by-unsigned 64-bit multiply, floored shift and saturation
`timescale 1ns / 1ps

module mjt_mulq #(
    parameter int K = 30
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_a,
    input  logic [63:0]        i_b,
    output logic               o_valid,
    output logic signed [63:0] o_p
);
    import mjt_pkg::*;

    logic [MULQ_LAT-1:0] r_v;
    logic                r1_neg, r2_neg, r3_neg;
    logic [63:0]         r1_mag, r1_b;
    logic [63:0]         r2_ll, r2_lh, r2_hl, r2_hh;
    logic [127:0]        r3_p;
    logic signed [63:0]  r4_p;

    logic                ovf, rem;
    logic [62:0]         q;
    logic [63:0]         mag;
    logic signed [63:0]  n_p;

    always_comb begin
        ovf = |r3_p[127:K+63];
        q   = r3_p[K+62:K];
        rem = |r3_p[K-1:0];
        mag = {1'b0, q} + {63'd0, rem};
        if (ovf) begin
            n_p = r3_neg ? SAT_MIN : SAT_MAX;
        end else if (r3_neg) begin
            n_p = -$signed(mag);
        end else begin
            n_p = $signed({1'b0, q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[MULQ_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg <= i_a[63];
            r1_mag <= i_a[63] ? (64'd0 - i_a) : i_a;
            r1_b   <= i_b;
            r2_neg <= r1_neg;
            r2_ll  <= r1_mag[31:0] * r1_b[31:0];
            r2_lh  <= r1_mag[31:0] * r1_b[63:32];
            r2_hl  <= r1_mag[63:32] * r1_b[31:0];
            r2_hh  <= r1_mag[63:32] * r1_b[63:32];
            r3_neg <= r2_neg;
            r3_p   <= {r2_hh, 64'd0} + {32'd0, r2_lh, 32'd0} + {32'd0, r2_hl, 32'd0}
                      + {64'd0, r2_ll};
            r4_p   <= n_p;
        end
    end

    assign o_valid = r_v[MULQ_LAT-1];
    assign o_p     = r4_p;

endmodule

### rtl/mjt_step.sv
// one horner step: floored product plus coefficient, sample sideband carried along
`timescale 1ns / 1ps

module mjt_step #(
    parameter int K = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [63:0]  i_x,
    input  logic [63:0]         i_b,
    input  logic signed [63:0]  i_c,
    input  mjt_pkg::t_side      i_side,
    output logic                o_valid,
    output logic signed [63:0]  o_x,
    output mjt_pkg::t_side      o_side
);
    import mjt_pkg::*;

    logic               mul_v;
    logic signed [63:0] mul_p;
    t_side              r_side_pipe [0:MULQ_LAT-1];
    logic               r_v;
    logic signed [63:0] r_x;
    t_side              r_side;

    mjt_mulq #(.K(K)) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (i_valid),
        .i_a     (i_x),
        .i_b     (i_b),
        .o_valid (mul_v),
        .o_p     (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_pipe[0] <= i_side;
            for (int i = 1; i < MULQ_LAT; i++) begin
                r_side_pipe[i] <= r_side_pipe[i-1];
            end
            r_x    <= mul_p + i_c;
            r_side <= r_side_pipe[MULQ_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= mul_v;
        end
    end

    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_side  = r_side;

endmodule

### rtl/mjt_sdiv.sv
// pipelined restoring divider for normalized time, one quotient bit per stage
`timescale 1ns / 1ps

module mjt_sdiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [mjt_pkg::DUR_W-1:0] i_elapsed,
    input  logic [mjt_pkg::DUR_W-1:0] i_dur,
    output logic                      o_valid,
    output mjt_pkg::t_side            o_side
);
    import mjt_pkg::*;

    logic [S_BITS:0]    r_v;
    logic [DUR_W-1:0]   r_rem  [0:S_BITS];
    logic [S_BITS-1:0]  r_q    [0:S_BITS];
    logic [S_BITS:0]    r_done;

    logic [DUR_W:0]     rem_sh [0:S_BITS-1];
    logic [DUR_W:0]     rem_nx [0:S_BITS-1];
    logic [S_BITS-1:0]  ge;

    always_comb begin
        for (int i = 0; i < S_BITS; i++) begin
            rem_sh[i] = {r_rem[i], 1'b0};
            ge[i]     = rem_sh[i] >= {1'b0, i_dur};
            rem_nx[i] = ge[i] ? (rem_sh[i] - {1'b0, i_dur}) : rem_sh[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[S_BITS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_elapsed;
            r_q[0]    <= '0;
            r_done[0] <= i_elapsed >= i_dur;
            for (int i = 0; i < S_BITS; i++) begin
                r_rem[i+1]  <= rem_nx[i][DUR_W-1:0];
                r_q[i+1]    <= {r_q[i][S_BITS-2:0], ge[i]};
                r_done[i+1] <= r_done[i];
            end
        end
    end

    assign o_valid     = r_v[S_BITS];
    assign o_side.s    = r_q[S_BITS];
    assign o_side.done = r_done[S_BITS];

endmodule

### rtl/mjt_setup.sv
// configuration registers and sequencer that derives the segment coefficients
`timescale 1ns / 1ps

module mjt_setup (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mjt_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [mjt_pkg::CFG_W-1:0] i_cfg_data,
    output mjt_pkg::t_coef            o_coef,
    output logic                      o_busy
);
    import mjt_pkg::*;

    t_setup_state       r_state, n_state;
    logic [31:0]        r_pos0, r_pos1, r_vel0, r_vel1, r_acc0, r_acc1;
    logic [DUR_W-1:0]   r_dur;

    logic [63:0]        r_num;
    logic [DUR_W-1:0]   r_den;
    logic [DUR_W-1:0]   r_rem;
    logic [5:0]         r_cnt;
    logic [2:0]         r_op;

    logic [38:0]        r_ts;
    logic [44:0]        r_ts2;
    logic [59:0]        r_it;
    logic signed [63:0] r_v0, r_vf, r_w0, r_wf;
    logic signed [63:0] r_n3, r_n4, r_n5;
    logic signed [63:0] r_n5x5, r_n4x4, r_n3x3, r_n5x20, r_n4x12, r_n3x6;
    logic signed [63:0] r_q0x2, r_v0x2, r_w0x2;

    logic [DUR_W:0]     rem_sh, rem_nx;
    logic               ge;
    logic [63:0]        num_nx;
    logic [39:0]        ts_num;
    logic [38:0]        ts_int;

    logic               mul_in_v, mul_v;
    logic signed [63:0] mul_a, mul_p;
    logic [63:0]        mul_b;

    logic signed [63:0] c_q0, c_qf, c_d, c_n3, c_n4, c_n5;

    // restoring divider, one quotient bit a cycle
    always_comb begin
        rem_sh = {r_rem, r_num[63]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        num_nx = {r_num[62:0], ge};
        // split of dur * 2^32 / 10^6 into a whole part and a remainder part
        ts_num = {14'd0, r_dur} * TS_FRAC + TS_HALF;
        ts_int = {13'd0, r_dur} * TS_INT;
    end

    always_comb begin
        mul_in_v = (r_state == ST_MUL_ISSUE);
        case (r_op)
            OP_TS: begin
                mul_a = $signed({24'd0, ts_num});
                mul_b = {23'd0, TS_RECIP};
            end
            OP_TS2: begin
                mul_a = $signed({25'd0, r_ts});
                mul_b = {25'd0, r_ts};
            end
            OP_V0: begin
                mul_a = $signed({{32{r_vel0[31]}}, r_vel0});
                mul_b = {25'd0, r_ts};
            end
            OP_VF: begin
                mul_a = $signed({{32{r_vel1[31]}}, r_vel1});
                mul_b = {25'd0, r_ts};
            end
            OP_W0: begin
                mul_a = $signed({{32{r_acc0[31]}}, r_acc0});
                mul_b = {19'd0, r_ts2};
            end
            OP_WF: begin
                mul_a = $signed({{32{r_acc1[31]}}, r_acc1});
                mul_b = {19'd0, r_ts2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mjt_mulq #(.K(SETUP_K)) u_mulq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (1'b1),
        .i_valid (mul_in_v),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_valid (mul_v),
        .o_p     (mul_p)
    );

    // doubled normalized-time coefficients
    always_comb begin
        c_q0 = $signed({{24{r_pos0[31]}}, r_pos0, 8'd0});
        c_qf = $signed({{24{r_pos1[31]}}, r_pos1, 8'd0});
        c_d  = c_qf - c_q0;
        c_n3 = 64'sd20 * c_d - 64'sd8 * r_vf - 64'sd12 * r_v0 - 64'sd3 * r_w0 + r_wf;
        c_n4 = 64'sd14 * r_vf + 64'sd16 * r_v0 + 64'sd3 * r_w0 - 64'sd30 * c_d
               - 64'sd2 * r_wf;
        c_n5 = 64'sd12 * c_d - 64'sd6 * r_vf - 64'sd6 * r_v0 - r_w0 + r_wf;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      n_state = ST_IDLE;
            ST_START:     n_state = ST_DIV_IT;
            ST_DIV_IT:    if (r_cnt == DIV_LAST) n_state = ST_MUL_ISSUE;
            ST_MUL_ISSUE: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_v) begin
                    n_state = (r_op == OP_WF) ? ST_COEF : ST_MUL_ISSUE;
                end
            end
            ST_COEF:      n_state = ST_SCALE;
            ST_SCALE:     n_state = ST_IDLE;
            default:      n_state = ST_START;
        endcase
        // any register write restarts the derivation
        if (i_cfg_we) begin
            n_state = ST_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos0 <= '0;
            r_pos1 <= '0;
            r_vel0 <= '0;
            r_vel1 <= '0;
            r_acc0 <= '0;
            r_acc1 <= '0;
            r_dur  <= DUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_POS: r_pos0 <= i_cfg_data;
                REG_END_POS:   r_pos1 <= i_cfg_data;
                REG_START_VEL: r_vel0 <= i_cfg_data;
                REG_END_VEL:   r_vel1 <= i_cfg_data;
                REG_START_ACC: r_acc0 <= i_cfg_data;
                REG_END_ACC:   r_acc1 <= i_cfg_data;
                REG_DURATION:  r_dur  <= i_cfg_data[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_START: begin
                r_num <= IT_NUM;
                r_den <= r_dur;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV_IT: begin
                r_num <= num_nx;
                r_rem <= rem_nx[DUR_W-1:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    r_it <= num_nx[59:0];
                    r_op <= OP_TS;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_v) begin
                    case (r_op)
                        OP_TS:   r_ts  <= ts_int + {12'd0, mul_p[56:30]};
                        OP_TS2:  r_ts2 <= mul_p[52:8];
                        OP_V0:   r_v0  <= mul_p;
                        OP_VF:   r_vf  <= mul_p;
                        OP_W0:   r_w0  <= mul_p;
                        OP_WF:   r_wf  <= mul_p;
                        default: ;
                    endcase
                    r_op <= r_op + 3'd1;
                end
            end
            ST_COEF: begin
                r_n3 <= c_n3;
                r_n4 <= c_n4;
                r_n5 <= c_n5;
            end
            ST_SCALE: begin
                r_n5x5  <= 64'sd5 * r_n5;
                r_n4x4  <= 64'sd4 * r_n4;
                r_n3x3  <= 64'sd3 * r_n3;
                r_n5x20 <= 64'sd20 * r_n5;
                r_n4x12 <= 64'sd12 * r_n4;
                r_n3x6  <= 64'sd6 * r_n3;
                r_q0x2  <= 64'sd2 * c_q0;
                r_v0x2  <= 64'sd2 * r_v0;
                r_w0x2  <= 64'sd2 * r_w0;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        o_coef.n5      = r_n5;
        o_coef.n4      = r_n4;
        o_coef.n3      = r_n3;
        o_coef.w0      = r_w0;
        o_coef.w0x2    = r_w0x2;
        o_coef.v0x2    = r_v0x2;
        o_coef.q0x2    = r_q0x2;
        o_coef.n5x5    = r_n5x5;
        o_coef.n4x4    = r_n4x4;
        o_coef.n3x3    = r_n3x3;
        o_coef.n5x20   = r_n5x20;
        o_coef.n4x12   = r_n4x12;
        o_coef.n3x6    = r_n3x6;
        o_coef.inv_t   = r_it;
        o_coef.end_pos = r_pos1;
        o_coef.end_vel = r_vel1;
        o_coef.end_acc = r_acc1;
        o_coef.dur     = r_dur;
    end

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_busy)
        else $error("register write did not restart coefficient setup");

endmodule

### rtl/min_jerk_trajectory_sample_top.sv
// top level of the one-axis minimum-jerk trajectory sampler
`timescale 1ns / 1ps

// usage
//  - slave stream carries elapsed time in microseconds, master stream returns
//    position, velocity and acceleration (Q16.16) of the quintic at that time
//  - tuser on the master side flags a sample at or past the segment end; such
//    a transfer carries the programmed end position, velocity and acceleration
//  - registers are written through i_cfg_we / i_cfg_index / i_cfg_data while
//    the stream is idle; each write starts a coefficient setup (one 64-step
//    division for 1/T and six multiplies on one shared unit), during which
//    o_s_tready is low
//  - after reset the same setup runs on the reset values before the first
//    sample is taken
//  - throughput: one sample per cycle while no setup runs and a stalled
//    receiver does not hold the pipeline, set by the fully pipelined divider
//    and the five multiply-add stages of each horner chain
//  - path from the accepting edge to o_m_tvalid: the input register, 30
//    divider stages, 5 horner steps of 5 stages each and 1 output stage
//  - when the receiver stalls, the result waits in the output register and the
//    pipeline keeps advancing as long as its last stage is empty; once that
//    stage holds a sample too, the whole pipeline and o_s_tready hold
module min_jerk_trajectory_sample_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [31:0]               i_s_tdata,   // [25:0] elapsed_us
    // master stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [95:0]               o_m_tdata,   // [31:0] position_out,
                                                   // [63:32] velocity_out,
                                                   // [95:64] acceleration_out
    output logic [0:0]                o_m_tuser,   // [0] segment_done
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [mjt_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [mjt_pkg::CFG_W-1:0] i_cfg_data
);
    import mjt_pkg::*;

    localparam int STEPS = 5;

    t_coef              coef;
    logic               busy;
    logic               en;

    // divider output feeds all three chains
    logic               div_v;
    t_side              div_side;

    // chain signals: position p, velocity y, acceleration z
    logic               p_v    [0:STEPS];
    logic               y_v    [0:STEPS];
    logic               z_v    [0:STEPS];
    logic signed [63:0] p_x    [0:STEPS];
    logic signed [63:0] y_x    [0:STEPS];
    logic signed [63:0] z_x    [0:STEPS];
    t_side              p_side [0:STEPS];
    t_side              y_side [0:STEPS];
    t_side              z_side [0:STEPS];
    logic signed [63:0] p_c    [0:STEPS-1];
    logic signed [63:0] y_c    [0:STEPS-1];
    logic signed [63:0] z_c    [0:STEPS-1];

    logic               r_out_v;
    logic [31:0]        r_out_pos, r_out_vel, r_out_acc;
    logic               r_out_done;

    // round half up from doubled guarded units, saturate to 32 bits
    function automatic logic [31:0] to_out(input logic signed [63:0] x);
        logic signed [63:0] y;
        logic signed [63:0] r;
        y = (x > SAT_MAX - 64'sd256) ? SAT_MAX : x + 64'sd256;
        r = y >>> (GUARD + 1);
        if (r > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (r < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return r[31:0];
        end
    endfunction

    mjt_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef),
        .o_busy      (busy)
    );

    // advance unless a finished sample meets a full, stalled output register
    assign en         = !r_out_v || i_m_tready || !p_v[STEPS];
    assign o_s_tready = en && !busy;

    mjt_sdiv u_sdiv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_s_tvalid && !busy),
        .i_elapsed (i_s_tdata[DUR_W-1:0]),
        .i_dur     (coef.dur),
        .o_valid   (div_v),
        .o_side    (div_side)
    );

    // horner seeds and addends
    always_comb begin
        p_v[0]    = div_v;
        y_v[0]    = div_v;
        z_v[0]    = div_v;
        p_side[0] = div_side;
        y_side[0] = div_side;
        z_side[0] = div_side;
        p_x[0]    = coef.n5;
        y_x[0]    = coef.n5x5;
        z_x[0]    = coef.n5x20;
        p_c[0] = coef.n4;    p_c[1] = coef.n3;    p_c[2] = coef.w0;
        p_c[3] = coef.v0x2;  p_c[4] = coef.q0x2;
        y_c[0] = coef.n4x4;  y_c[1] = coef.n3x3;  y_c[2] = coef.w0x2;
        y_c[3] = coef.v0x2;  y_c[4] = '0;
        z_c[0] = coef.n4x12; z_c[1] = coef.n3x6;  z_c[2] = coef.w0x2;
        z_c[3] = '0;         z_c[4] = '0;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_chain
        // velocity scales by 1/T in its last step, acceleration in its last two
        localparam bit Y_INV = (i == STEPS - 1);
        localparam bit Z_INV = (i >= STEPS - 2);
        localparam int YK    = Y_INV ? INV_BITS : S_BITS;
        localparam int ZK    = Z_INV ? INV_BITS : S_BITS;

        logic [63:0] p_b, y_b, z_b;

        assign p_b = {{(64-S_BITS){1'b0}}, p_side[i].s};
        assign y_b = Y_INV ? {4'd0, coef.inv_t} : {{(64-S_BITS){1'b0}}, y_side[i].s};
        assign z_b = Z_INV ? {4'd0, coef.inv_t} : {{(64-S_BITS){1'b0}}, z_side[i].s};

        mjt_step #(.K(S_BITS)) u_p (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_valid (p_v[i]), .i_x (p_x[i]), .i_b (p_b), .i_c (p_c[i]),
            .i_side (p_side[i]),
            .o_valid (p_v[i+1]), .o_x (p_x[i+1]), .o_side (p_side[i+1])
        );

        mjt_step #(.K(YK)) u_y (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_valid (y_v[i]), .i_x (y_x[i]), .i_b (y_b), .i_c (y_c[i]),
            .i_side (y_side[i]),
            .o_valid (y_v[i+1]), .o_x (y_x[i+1]), .o_side (y_side[i+1])
        );

        mjt_step #(.K(ZK)) u_z (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_valid (z_v[i]), .i_x (z_x[i]), .i_b (z_b), .i_c (z_c[i]),
            .i_side (z_side[i]),
            .o_valid (z_v[i+1]), .o_x (z_x[i+1]), .o_side (z_side[i+1])
        );
    end

    // output register, end point substituted for samples at or past the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en && p_v[STEPS]) begin
            r_out_v <= 1'b1;
        end else if (i_m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && p_v[STEPS]) begin
            r_out_done <= p_side[STEPS].done;
            if (p_side[STEPS].done) begin
                r_out_pos <= coef.end_pos;
                r_out_vel <= coef.end_vel;
                r_out_acc <= coef.end_acc;
            end else begin
                r_out_pos <= to_out(p_x[STEPS]);
                r_out_vel <= to_out(y_x[STEPS]);
                r_out_acc <= to_out(z_x[STEPS]);
            end
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = {r_out_acc, r_out_vel, r_out_pos};
    assign o_m_tuser[0] = r_out_done;

    // the three chains move in lockstep
    a_chain_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (p_v[STEPS] == y_v[STEPS]) && (p_v[STEPS] == z_v[STEPS]))
        else $error("horner chains out of step");

    a_chain_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_v[STEPS] |-> (y_side[STEPS] == p_side[STEPS]) && (z_side[STEPS] == p_side[STEPS]))
        else $error("horner chains carry different samples");

    a_reset_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule
